/* rtl/core/mrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_pkg: shared definitions for the MQTT receive parser
// Limits, field widths and the event and error codes seen on the result port.
// ----------------------------------------------------------------------------
package mrp_pkg;

  // Packet limits
  localparam int unsigned BODY_BYTES  = 512;
  localparam int unsigned TOPIC_BYTES = 128;

  // Field and counter widths
  localparam int BL_W    = 28;                    // remaining length, four 7-bit groups
  localparam int TOPIC_W = $clog2(TOPIC_BYTES);   // topic length below the limit
  localparam int PL_W    = 9;                     // reported payload length

  typedef logic [BL_W-1:0]    bl_t;
  typedef logic [TOPIC_W-1:0] topic_size_t;
  typedef logic [PL_W-1:0]    payload_size_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TOPIC   = 2'd1,
    EV_PAYLOAD = 2'd2,
    EV_ERROR   = 2'd3
  } event_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_LEN_BYTES = 3'd1,
    ERR_BODY_SIZE = 3'd2,
    ERR_TOPIC_LEN = 3'd3,
    ERR_OVERRUN   = 3'd4
  } err_t;

  localparam logic [3:0] PUBLISH_TYPE = 4'h3;

endpackage

/* rtl/core/mqtt_receive_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_receive_parser_unit: byte-wide MQTT 3.1.1 receive parser
// Takes one received byte per transaction and gives one result per byte:
// topic bytes, payload bytes, packet end marks and parse errors.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------
// input    | in_valid  / in_stall       | rx_byte
// result   | out_valid / out_stall      | event_res, data_byte, packet_done,
//          |                            | error_code, msg_qos, topic_length,
//          |                            | payload_length
//
// One byte is taken every clock cycle while in_stall is low; its result
// appears in the output register on the next cycle. All parsing for a byte
// is one pass of logic between the parser state and the output register.
// in_stall is raised only while the output register holds a result that the
// sink is stalling; a result taken in the same cycle frees the slot at once.
// Synchronous active-high reset returns the parser to waiting for a header
// byte and empties the output register.
//
module mqtt_receive_parser_unit (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  event_res,
  output logic [7:0]                  data_byte,
  output logic                        packet_done,
  output logic [2:0]                  error_code,
  output logic [1:0]                  msg_qos,
  output logic [mrp_pkg::TOPIC_W-1:0] topic_length,
  output logic [mrp_pkg::PL_W-1:0]    payload_length
);

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE,      // waiting for a fixed header byte
    PH_LEN,       // remaining length bytes
    PH_TLEN_HI,   // topic length, high byte
    PH_TLEN_LO,   // topic length, low byte
    PH_TOPIC,     // topic bytes
    PH_PID,       // packet id, skipped
    PH_PAYLOAD,   // payload bytes
    PH_SKIP       // body of a packet other than PUBLISH
  } phase_t;

  // Parser state
  phase_t                phase, phase_next;
  logic                  is_publish, is_publish_next;  // header type is PUBLISH
  logic [1:0]            qos, qos_next;                // header bits 2:1
  logic [2:0]            len_count, len_count_next;    // length bytes seen, 0..4
  mrp_pkg::bl_t          bytes_left, bytes_left_next;  // body bytes still to come
  logic [7:0]            tlen_hi, tlen_hi_next;        // topic length high byte
  mrp_pkg::topic_size_t  topic_size, topic_size_next;
  mrp_pkg::topic_size_t  topic_left, topic_left_next;
  logic [1:0]            pid_left, pid_left_next;
  mrp_pkg::payload_size_t payload_size, payload_size_next;

  // Result of the byte in flight
  mrp_pkg::event_t       ev;
  mrp_pkg::err_t         err;
  logic [7:0]            data;
  logic                  done;
  logic                  info;   // PUBLISH details are reported

  logic                  in_take;

  // Working values for the topic length check
  logic [15:0]           tlen_full;
  logic [1:0]            pid_len;
  mrp_pkg::bl_t          bl_dec;

  // Pick the next PUBLISH section from the counts after this byte
  function automatic phase_t publish_advance(mrp_pkg::topic_size_t tl, logic [1:0] pl,
                                             mrp_pkg::bl_t bl);
    phase_t p;
    if (tl != '0) begin
      p = PH_TOPIC;
    end else if (pl != '0) begin
      p = PH_PID;
    end else if (bl != '0) begin
      p = PH_PAYLOAD;
    end else begin
      p = PH_IDLE;
    end
    return p;
  endfunction

  // The output register is free, or is being emptied this cycle
  assign in_stall = out_valid & out_stall;
  assign in_take  = in_valid & ~in_stall;

  assign tlen_full = {tlen_hi, rx_byte};
  assign pid_len   = (qos != 2'd0) ? 2'd2 : 2'd0;
  assign bl_dec    = bytes_left - mrp_pkg::bl_t'(1);

  always_comb begin
    phase_next        = phase;
    is_publish_next   = is_publish;
    qos_next          = qos;
    len_count_next    = len_count;
    bytes_left_next   = bytes_left;
    tlen_hi_next      = tlen_hi;
    topic_size_next   = topic_size;
    topic_left_next   = topic_left;
    pid_left_next     = pid_left;
    payload_size_next = payload_size;
    ev                = mrp_pkg::EV_NONE;
    err               = mrp_pkg::ERR_NONE;
    data              = 8'd0;
    done              = 1'b0;
    info              = 1'b0;

    case (phase)
      PH_IDLE: begin
        is_publish_next = (rx_byte[7:4] == mrp_pkg::PUBLISH_TYPE);
        qos_next        = rx_byte[2:1];
        len_count_next  = 3'd0;
        bytes_left_next = '0;
        phase_next      = PH_LEN;
      end

      PH_LEN: begin
        if (len_count[2]) begin
          err = mrp_pkg::ERR_LEN_BYTES;
        end else begin
          // 7-bit groups, least significant first; groups never overlap
          bytes_left_next = bytes_left
                          | (mrp_pkg::bl_t'(rx_byte[6:0]) << (7 * len_count[1:0]));
          len_count_next  = len_count + 3'd1;
          if (!rx_byte[7]) begin
            if (is_publish) begin
              if (bytes_left_next > mrp_pkg::bl_t'(mrp_pkg::BODY_BYTES)) begin
                err = mrp_pkg::ERR_BODY_SIZE;
              end else if (bytes_left_next < mrp_pkg::bl_t'(2)) begin
                err = mrp_pkg::ERR_OVERRUN;
              end else begin
                phase_next = PH_TLEN_HI;
              end
            end else if (bytes_left_next == '0) begin
              done       = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end

      PH_TLEN_HI: begin
        tlen_hi_next    = rx_byte;
        bytes_left_next = bl_dec;
        phase_next      = PH_TLEN_LO;
      end

      PH_TLEN_LO: begin
        bytes_left_next = bl_dec;
        if (tlen_full >= 16'(mrp_pkg::TOPIC_BYTES)) begin
          err = mrp_pkg::ERR_TOPIC_LEN;
        end else if (mrp_pkg::bl_t'(tlen_full) + mrp_pkg::bl_t'(pid_len) > bl_dec) begin
          err = mrp_pkg::ERR_OVERRUN;
        end else begin
          topic_size_next   = tlen_full[mrp_pkg::TOPIC_W-1:0];
          topic_left_next   = tlen_full[mrp_pkg::TOPIC_W-1:0];
          pid_left_next     = pid_len;
          payload_size_next = mrp_pkg::PL_W'(bl_dec - mrp_pkg::bl_t'(tlen_full)
                                             - mrp_pkg::bl_t'(pid_len));
          info              = 1'b1;
          phase_next        = publish_advance(topic_left_next, pid_left_next, bl_dec);
          done              = (phase_next == PH_IDLE);
        end
      end

      PH_TOPIC: begin
        ev              = mrp_pkg::EV_TOPIC;
        data            = rx_byte;
        info            = 1'b1;
        topic_left_next = topic_left - mrp_pkg::topic_size_t'(1);
        bytes_left_next = bl_dec;
        phase_next      = publish_advance(topic_left_next, pid_left, bl_dec);
        done            = (phase_next == PH_IDLE);
      end

      PH_PID: begin
        info            = 1'b1;
        pid_left_next   = pid_left - 2'd1;
        bytes_left_next = bl_dec;
        phase_next      = publish_advance(topic_left, pid_left_next, bl_dec);
        done            = (phase_next == PH_IDLE);
      end

      PH_PAYLOAD: begin
        ev              = mrp_pkg::EV_PAYLOAD;
        data            = rx_byte;
        info            = 1'b1;
        bytes_left_next = bl_dec;
        phase_next      = publish_advance(topic_left, pid_left, bl_dec);
        done            = (phase_next == PH_IDLE);
      end

      PH_SKIP: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          done       = 1'b1;
          phase_next = PH_IDLE;
        end
      end

      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // Any error ends the packet; wait for a fresh header
    if (err != mrp_pkg::ERR_NONE) begin
      ev         = mrp_pkg::EV_ERROR;
      data       = 8'd0;
      done       = 1'b1;
      info       = 1'b0;
      phase_next = PH_IDLE;
    end
  end

  // Parser state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      len_count   <= 3'd0;
      bytes_left  <= '0;
      topic_left  <= '0;
      pid_left    <= 2'd0;
      out_valid   <= 1'b0;
    end else begin
      if (in_take) begin
        phase          <= phase_next;
        is_publish     <= is_publish_next;
        qos            <= qos_next;
        len_count      <= len_count_next;
        bytes_left     <= bytes_left_next;
        tlen_hi        <= tlen_hi_next;
        topic_size     <= topic_size_next;
        topic_left     <= topic_left_next;
        pid_left       <= pid_left_next;
        payload_size   <= payload_size_next;

        out_valid      <= 1'b1;
        event_res      <= ev;
        data_byte      <= data;
        packet_done    <= done;
        error_code     <= err;
        msg_qos        <= info ? qos : 2'd0;
        topic_length   <= info ? topic_size_next : '0;
        payload_length <= info ? payload_size_next : '0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/mrp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_checker: port-level checks for the MQTT receive parser
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
module mrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] event_res,
  input logic [7:0] data_byte,
  input logic       packet_done,
  input logic [2:0] error_code
);

  // Every accepted byte leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted byte gave no result");

  // A stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(event_res) && $stable(data_byte)
                                  && $stable(packet_done) && $stable(error_code)))
    else $error("stalled result changed");

  // An error ends the packet and carries a code
  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == mrp_pkg::EV_ERROR)
      |-> (packet_done && error_code != mrp_pkg::ERR_NONE))
    else $error("error result without code or end mark");

  // Error code only on error events
  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != mrp_pkg::EV_ERROR) |-> (error_code == mrp_pkg::ERR_NONE))
    else $error("error code on a non-error result");

  // Data byte is zero unless a topic or payload byte is reported
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == mrp_pkg::EV_NONE || event_res == mrp_pkg::EV_ERROR))
      |-> (data_byte == 8'd0))
    else $error("data byte set without topic or payload event");

endmodule

bind mqtt_receive_parser_unit mrp_checker u_mrp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_res   (event_res),
  .data_byte   (data_byte),
  .packet_done (packet_done),
  .error_code  (error_code)
);
